// File: hdl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants of the max-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int KEY_W            = 32;
    localparam int PL_W             = 32;
    localparam int OCC_W            = 9;
    localparam int DEF_CAPACITY     = 256;
    localparam int DEF_PAYLOAD_BITS = 32;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_DEL_ROOT,
        S_DEL_LAST,
        S_DEL_LOAD,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PL_W-1:0]  payload;
        status_t          status;
        logic [OCC_W-1:0] occupancy;
    } res_t;

endpackage

// File: hdl/max_heap_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue_unit
// Binary max-heap priority queue of key/payload entries with insert and
// remove-max commands, one result item per command item.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                     | tuser
//  s_      | in  | key[31:0], payload[63:32]              | command[0]
//  m_      | out | out_key[31:0], out_payload[63:32],     | status[1:0]
//          |     | occupancy[72:64], zero[79:73]          |
//
//  Insert climbs the entry until it reaches the root or a compare stops it;
//  remove sinks it until it stops at a node without children or a compare
//  stops it. The single read port of the entry memory sets the pace: each
//  level needs its reads done one at a time before the shared compare.
//  Reset clears the entry count; memory contents need no clearing.
//  s_tready is low while an item is in work; a finished item waits in the
//  output register while the next item is accepted.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_unit #(
    parameter int CAPACITY     = mhpq_pkg::DEF_CAPACITY,
    parameter int PAYLOAD_BITS = mhpq_pkg::DEF_PAYLOAD_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key[31:0], payload[63:32]
    input  logic [0:0]  s_tuser,   // command[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // out_key[31:0], out_payload[63:32], occupancy[72:64]
    output logic [1:0]  m_tuser    // status[1:0]
);

    import mhpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int DW = KEY_W + PAYLOAD_BITS;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [DW-1:0] rd_data, wr_data;
    logic          done_valid, done_ready, take;
    res_t          done_res;
    res_t          out_reg;
    logic          m_valid_reg;

    mhpq_seq #(
        .CAPACITY     (CAPACITY),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser[0]),
        .in_key     (s_tdata[31:0]),
        .in_payload (s_tdata[63:32]),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .done_valid (done_valid),
        .done_ready (done_ready),
        .done_res   (done_res)
    );

    mhpq_store #(
        .DEPTH  (CAPACITY),
        .DATA_W (DW)
    ) u_store (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign done_ready = !m_valid_reg || m_tready;
    assign take       = done_valid && done_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (take) begin
            out_reg <= done_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, out_reg.occupancy, out_reg.payload, out_reg.key};
    assign m_tuser  = out_reg.status;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in work");

    a_full_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_FULL |-> m_tdata[72:64] == OCC_W'(CAPACITY))
        else $error("full status with occupancy below capacity");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_EMPTY |-> m_tdata[72:0] == '0)
        else $error("empty status with nonzero entry or occupancy");

    a_error_no_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_DONE |-> m_tdata[63:0] == '0)
        else $error("error status carries an entry");

endmodule

// File: hdl/mhpq_store.sv
// ----------------------------------------------------------------------------
// mhpq_store
// Heap entry memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mhpq_store #(
    parameter  int DEPTH  = 256,
    parameter  int DATA_W = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/mhpq_seq.sv
// ----------------------------------------------------------------------------
// mhpq_seq
// Sequencer and shared compare/index unit for sift-up and sift-down.
// ----------------------------------------------------------------------------
module mhpq_seq #(
    parameter  int CAPACITY     = 256,
    parameter  int PAYLOAD_BITS = 32,
    localparam int AW           = $clog2(CAPACITY),
    localparam int CW           = $clog2(CAPACITY + 1),
    localparam int DW           = 32 + PAYLOAD_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_cmd,
    input  logic [31:0]           in_key,
    input  logic [31:0]           in_payload,
    output logic                  rd_en,
    output logic [AW-1:0]         rd_addr,
    input  logic [DW-1:0]         rd_data,
    output logic                  wr_en,
    output logic [AW-1:0]         wr_addr,
    output logic [DW-1:0]         wr_data,
    output logic                  done_valid,
    input  logic                  done_ready,
    output mhpq_pkg::res_t        done_res
);

    import mhpq_pkg::*;

    localparam int CHW = AW + 2;

    state_t                  state_reg, state_next;
    logic [AW-1:0]           node_reg, node_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [KEY_W-1:0]        k_reg, k_next;
    logic [PAYLOAD_BITS-1:0] p_reg, p_next;
    logic [DW-1:0]           lft_reg, lft_next;
    logic [KEY_W-1:0]        okey_reg, okey_next;
    logic [PL_W-1:0]         opl_reg, opl_next;
    status_t                 status_reg, status_next;

    logic [AW-1:0]  node_m1, parent;
    logic [CHW-1:0] lchild, rchild, count_x;
    logic           l_ok, r_ok, par_lt, left_gt, right_gt, full, empty;
    logic [KEY_W-1:0] pick_key;
    logic [DW-1:0]  own_entry;

    // shared index and compare unit
    always_comb begin
        node_m1   = node_reg - AW'(1);
        parent    = node_m1 >> 1;
        lchild    = {1'b0, node_reg, 1'b1};
        rchild    = lchild + CHW'(1);
        count_x   = CHW'(count_reg);
        l_ok      = lchild < count_x;
        r_ok      = rchild < count_x;
        par_lt    = $signed(rd_data[DW-1 -: KEY_W]) < $signed(k_reg);
        left_gt   = $signed(lft_reg[DW-1 -: KEY_W]) > $signed(k_reg);
        pick_key  = left_gt ? lft_reg[DW-1 -: KEY_W] : k_reg;
        right_gt  = r_ok && ($signed(rd_data[DW-1 -: KEY_W]) > $signed(pick_key));
        full      = count_reg == CW'(CAPACITY);
        empty     = count_reg == '0;
        own_entry = {k_reg, p_reg};
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    if (in_cmd == CMD_INSERT) begin
                        state_next = full ? S_FINISH : S_INS_RD;
                    end else begin
                        state_next = empty ? S_FINISH : S_DEL_ROOT;
                    end
                end
            end
            S_INS_RD:   state_next = (node_reg == '0) ? S_FINISH : S_INS_CMP;
            S_INS_CMP:  state_next = par_lt ? S_INS_RD : S_FINISH;
            S_DEL_ROOT: state_next = S_DEL_LAST;
            S_DEL_LAST: state_next = S_DEL_LOAD;
            S_DEL_LOAD: state_next = S_DN_RDL;
            S_DN_RDL:   state_next = l_ok ? S_DN_RDR : S_FINISH;
            S_DN_RDR:   state_next = S_DN_CMP;
            S_DN_CMP:   state_next = (left_gt || right_gt) ? S_DN_RDL : S_FINISH;
            S_FINISH:   state_next = done_ready ? S_IDLE : S_FINISH;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb begin
        node_next   = node_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        p_next      = p_reg;
        lft_next    = lft_reg;
        okey_next   = okey_reg;
        opl_next    = opl_reg;
        status_next = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    okey_next   = '0;
                    opl_next    = '0;
                    status_next = ST_DONE;
                    if (in_cmd == CMD_INSERT) begin
                        if (full) begin
                            status_next = ST_FULL;
                        end else begin
                            k_next     = in_key;
                            p_next     = PAYLOAD_BITS'(in_payload);
                            node_next  = AW'(count_reg);
                            count_next = count_reg + CW'(1);
                        end
                    end else if (empty) begin
                        status_next = ST_EMPTY;
                    end
                end
            end
            S_INS_CMP: begin
                if (par_lt) begin
                    node_next = parent;
                end
            end
            S_DEL_LAST: begin
                okey_next  = rd_data[DW-1 -: KEY_W];
                opl_next   = PL_W'(rd_data[PAYLOAD_BITS-1:0]);
                count_next = count_reg - CW'(1);
            end
            S_DEL_LOAD: begin
                k_next    = rd_data[DW-1 -: KEY_W];
                p_next    = rd_data[PAYLOAD_BITS-1:0];
                node_next = '0;
            end
            S_DN_RDR: begin
                lft_next = rd_data;
            end
            S_DN_CMP: begin
                if (right_gt) begin
                    node_next = rchild[AW-1:0];
                end else if (left_gt) begin
                    node_next = lchild[AW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        in_ready   = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = node_reg;
        wr_data    = own_entry;
        done_valid = 1'b0;
        case (state_reg)
            S_IDLE: in_ready = 1'b1;
            S_INS_RD: begin
                if (node_reg == '0) begin
                    wr_en = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = parent;
                end
            end
            S_INS_CMP: begin
                wr_en   = 1'b1;
                wr_data = par_lt ? rd_data : own_entry;
            end
            S_DEL_ROOT: rd_en = 1'b1;
            S_DEL_LAST: begin
                rd_en   = 1'b1;
                rd_addr = AW'(count_reg - CW'(1));
            end
            S_DN_RDL: begin
                if (l_ok) begin
                    rd_en   = 1'b1;
                    rd_addr = lchild[AW-1:0];
                end else begin
                    wr_en = 1'b1;
                end
            end
            S_DN_RDR: begin
                rd_en   = r_ok;
                rd_addr = rchild[AW-1:0];
            end
            S_DN_CMP: begin
                wr_en   = 1'b1;
                wr_data = right_gt ? rd_data : (left_gt ? lft_reg : own_entry);
            end
            S_FINISH: done_valid = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
        end
        node_reg   <= node_next;
        k_reg      <= k_next;
        p_reg      <= p_next;
        lft_reg    <= lft_next;
        okey_reg   <= okey_next;
        opl_reg    <= opl_next;
        status_reg <= status_next;
    end

    assign done_res.key       = okey_reg;
    assign done_res.payload   = opl_reg;
    assign done_res.status    = status_reg;
    assign done_res.occupancy = OCC_W'(count_reg);

endmodule

// File: tb/sv/tb_max_heap_priority_queue_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_max_heap_priority_queue_unit
// Stream-level check of the max-heap priority queue. A clocked driver sends
// insert and remove-max items from a pending queue, and a clocked monitor
// keeps a software heap that predicts every result and compares each result
// item field by field. Stimulus runs a short directed set first: remove on
// empty, extreme keys and payloads, and equal keys. Random fill, drain and
// mixed phases follow, reaching the full queue and the empty queue several
// times. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_max_heap_priority_queue_unit;

    import mhpq_pkg::*;

    localparam int HEAP_DEPTH  = DEF_CAPACITY;
    localparam int RAND_ITEMS  = 1200;
    localparam int WATCHDOG    = 4000;
    localparam int DRAIN_WAIT  = 50;

    typedef struct {
        logic        cmd;
        logic [31:0] key;
        logic [31:0] payload;
    } heap_cmd_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;

    heap_cmd_t   cmd_q[$];
    res_t        result_q[$];

    logic signed [31:0] heap_key [HEAP_DEPTH];
    logic [31:0]        heap_pl  [HEAP_DEPTH];
    int                 heap_cnt = 0;

    int          mismatches   = 0;
    int          idle_cycles  = 0;
    logic        in_taken     = 1'b0;
    int          src_gap      = 0;
    int          src_calm     = 0;
    int          sink_stall   = 0;
    int          sink_calm    = 0;
    int          gen_cnt      = 0;
    int          gen_total    = 0;

    max_heap_priority_queue_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    // software heap: applies one command and returns the expected result
    function automatic res_t heap_apply(logic cmd, logic signed [31:0] k, logic [31:0] p);
        res_t               r;
        int                 i;
        int                 par;
        int                 node;
        int                 lc;
        int                 rc;
        int                 best;
        logic signed [31:0] best_key;
        logic signed [31:0] hk;
        logic [31:0]        hp;
        bit                 walking;
        r = '0;
        r.status = ST_DONE;
        if (cmd == CMD_INSERT) begin
            if (heap_cnt >= HEAP_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                i = heap_cnt;
                heap_cnt++;
                walking = 1'b1;
                while (walking && i > 0) begin
                    par = (i - 1) / 2;
                    if (heap_key[par] < k) begin
                        heap_key[i] = heap_key[par];
                        heap_pl[i]  = heap_pl[par];
                        i = par;
                    end else begin
                        walking = 1'b0;
                    end
                end
                heap_key[i] = k;
                heap_pl[i]  = p;
            end
        end else begin
            if (heap_cnt == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.key     = heap_key[0];
                r.payload = heap_pl[0];
                heap_cnt--;
                hk = heap_key[heap_cnt];
                hp = heap_pl[heap_cnt];
                node = 0;
                walking = 1'b1;
                while (walking) begin
                    lc = 2 * node + 1;
                    rc = 2 * node + 2;
                    best = node;
                    best_key = hk;
                    if (lc < heap_cnt && heap_key[lc] > best_key) begin
                        best = lc;
                        best_key = heap_key[lc];
                    end
                    if (rc < heap_cnt && heap_key[rc] > best_key) begin
                        best = rc;
                    end
                    if (best == node) begin
                        walking = 1'b0;
                    end else begin
                        heap_key[node] = heap_key[best];
                        heap_pl[node]  = heap_pl[best];
                        node = best;
                    end
                end
                heap_key[node] = hk;
                heap_pl[node]  = hp;
            end
        end
        r.occupancy = heap_cnt[OCC_W-1:0];
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] rand_key();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2, 3: begin
                return $urandom;
            end
            4, 5, 6: begin
                return $urandom_range(0, 16) - 8;
            end
            7: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            8: begin
                return 32'h7fff_ffff - $urandom_range(0, 3);
            end
            default: begin
                return 32'h8000_0000 + $urandom_range(0, 3);
            end
        endcase
    endfunction

    function automatic logic [31:0] rand_payload();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return 32'h0;
        end else if (r == 1) begin
            return 32'hffff_ffff;
        end
        return $urandom;
    endfunction

    task automatic push_item(logic cmd, logic [31:0] k, logic [31:0] p);
        heap_cmd_t c;
        c.cmd = cmd;
        c.key = k;
        c.payload = p;
        cmd_q.push_back(c);
    endtask

    // random command with the given percentage of inserts, count tracked
    task automatic push_random(int ins_pct);
        if ($urandom_range(0, 99) < ins_pct) begin
            push_item(CMD_INSERT, rand_key(), rand_payload());
            if (gen_cnt < HEAP_DEPTH) gen_cnt++;
        end else begin
            // remove item: key and payload lanes carry junk, ignored
            push_item(CMD_REMOVE, $urandom, $urandom);
            if (gen_cnt > 0) gen_cnt--;
        end
        gen_total++;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t MISMATCH %s: got %0h, want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic wait_drained();
        while (cmd_q.size() != 0 || s_tvalid || result_q.size() != 0) @(posedge aclk);
    endtask

    // driver
    always @(negedge aclk) begin
        heap_cmd_t c;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_taken) begin
            s_tvalid <= 1'b1;
        end else if (src_gap > 0) begin
            s_tvalid <= 1'b0;
            src_gap--;
        end else if (cmd_q.size() != 0) begin
            c = cmd_q.pop_front();
            s_tdata  <= {c.payload, c.key};
            s_tuser  <= c.cmd;
            s_tvalid <= 1'b1;
            if (src_calm > 0) begin
                src_calm--;
                src_gap = 0;
            end else begin
                if ($urandom_range(0, 99) < 3) src_calm = $urandom_range(20, 80);
                src_gap = ($urandom_range(0, 99) < 50) ? 0 : gap_len();
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // result backpressure
    always @(negedge aclk) begin
        if (sink_stall > 0) begin
            m_tready <= 1'b0;
            sink_stall--;
        end else if (sink_calm == 0 && $urandom_range(0, 99) < 20) begin
            m_tready <= 1'b0;
            sink_stall = gap_len() - 1;
        end else begin
            m_tready <= 1'b1;
        end
        if (sink_calm > 0) begin
            sink_calm--;
        end else if ($urandom_range(0, 99) < 2) begin
            sink_calm = $urandom_range(30, 120);
        end
    end

    // monitor: check results, predict accepted items, watchdog
    always @(posedge aclk) begin
        res_t e;
        in_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    report_mismatch("result item with none expected", m_tdata[31:0], 32'h0);
                end else begin
                    e = result_q.pop_front();
                    if (m_tdata[31:0] !== e.key)
                        report_mismatch("out_key", m_tdata[31:0], e.key);
                    if (m_tdata[63:32] !== e.payload)
                        report_mismatch("out_payload", m_tdata[63:32], e.payload);
                    if (m_tuser !== e.status)
                        report_mismatch("status", {30'h0, m_tuser}, {30'h0, e.status});
                    if (m_tdata[72:64] !== e.occupancy)
                        report_mismatch("occupancy", {23'h0, m_tdata[72:64]},
                                        {23'h0, e.occupancy});
                end
            end
            if (s_tvalid && s_tready) begin
                result_q.push_back(heap_apply(s_tuser[0], s_tdata[31:0], s_tdata[63:32]));
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        int phase;
        int extra;
        int n;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty remove, extremes, equal keys, full drain
        push_item(CMD_REMOVE, 32'hffff_ffff, 32'hffff_ffff);
        push_item(CMD_INSERT, 32'h0000_0000, 32'h0000_0000);
        push_item(CMD_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
        push_item(CMD_INSERT, 32'h8000_0000, 32'ha5a5_a5a5);
        push_item(CMD_INSERT, 32'hffff_ffff, 32'h5a5a_5a5a);
        push_item(CMD_INSERT, 32'h0000_0005, 32'h0000_0001);
        push_item(CMD_INSERT, 32'h0000_0005, 32'h0000_0002);
        push_item(CMD_INSERT, 32'h0000_0005, 32'h0000_0003);
        push_item(CMD_INSERT, 32'h0000_0005, 32'h0000_0004);
        push_item(CMD_INSERT, 32'h7fff_ffff, 32'h0000_0005);
        for (int i = 0; i < 10; i++) push_item(CMD_REMOVE, $urandom, $urandom);
        push_item(CMD_REMOVE, 32'h0, 32'h0);
        wait_drained();

        // random phases: fill to full, drain to empty, mixed
        phase = 0;
        gen_cnt = 0;
        while (gen_total < RAND_ITEMS) begin
            case (phase % 3)
                0: begin
                    extra = $urandom_range(1, 4);
                    while (extra > 0) begin
                        if (gen_cnt == HEAP_DEPTH) extra--;
                        push_random(80);
                    end
                end
                1: begin
                    extra = $urandom_range(1, 4);
                    while (extra > 0) begin
                        if (gen_cnt == 0) extra--;
                        push_random(20);
                    end
                end
                default: begin
                    n = $urandom_range(40, 120);
                    for (int i = 0; i < n; i++) push_random(50);
                end
            endcase
            if (phase == 0) wait_drained();
            phase++;
        end
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatches == 0 && result_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: max_heap_priority_queue_unit.f
hdl/mhpq_pkg.sv
hdl/mhpq_store.sv
hdl/mhpq_seq.sv
hdl/max_heap_priority_queue_unit.sv
tb/sv/tb_max_heap_priority_queue_unit.sv
